FILE: hdl/pixel_xor_chain_cipher_assert.svh
// assertion macros used by the checker file
`ifndef PIXEL_XOR_CHAIN_CIPHER_ASSERT_SVH
`define PIXEL_XOR_CHAIN_CIPHER_ASSERT_SVH

// same-cycle implication
`define PXCC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pixel_xor_chain_cipher check failed");

// next-cycle implication
`define PXCC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pixel_xor_chain_cipher check failed");

`endif

FILE: hdl/pxcc_pkg.sv
`timescale 1ns / 1ps

package pxcc_pkg;

   // xorshift32 shift amounts
   localparam int XS_SHIFT_A = 13;
   localparam int XS_SHIFT_B = 17;
   localparam int XS_SHIFT_C = 5;

   localparam int PIX_BITS      = 24;
   localparam int WORD_BITS     = 32;
   localparam int CSR_ADDR_BITS = 4;

   // register indexes, byte address is 4 * index
   typedef enum logic [1:0] {
      REG_KEY_SEED,
      REG_START_VALUE,
      REG_PIXEL_COUNT,
      REG_DECRYPT_MODE
   } csr_reg_type;

   // command from the sequencer to the keystream unit
   typedef struct packed {
      logic start;   // begin a run of steps
      logic reload;  // load the seed and run the frame skip
   } ks_ctrl_type;

endpackage

FILE: hdl/pxcc_keystream.sv
`timescale 1ns / 1ps

module pxcc_keystream #(
   parameter int COUNT_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pxcc_pkg::ks_ctrl_type         ctrl,
   input  logic [pxcc_pkg::WORD_BITS-1:0] seed,
   input  logic [COUNT_BITS-1:0]         steps,
   output logic                          busy,
   output logic [pxcc_pkg::WORD_BITS-1:0] word
);
   import pxcc_pkg::*;

   logic [WORD_BITS-1:0]  word_ff;
   logic [WORD_BITS-1:0]  word_in;
   logic [COUNT_BITS-1:0] remain_ff;
   logic [COUNT_BITS-1:0] remain_in;

   function automatic logic [WORD_BITS-1:0] xs_step(input logic [WORD_BITS-1:0] x);
      logic [WORD_BITS-1:0] a;
      logic [WORD_BITS-1:0] b;
      a = x ^ (x << XS_SHIFT_A);
      b = a ^ (a >> XS_SHIFT_B);
      return b ^ (b << XS_SHIFT_C);
   endfunction

   // the one shared step unit, advanced once per cycle while steps remain
   always_comb begin
      word_in   = word_ff;
      remain_in = remain_ff;
      if (ctrl.start) begin
         if (ctrl.reload) begin
            word_in   = seed;
            remain_in = steps;
         end else begin
            remain_in = COUNT_BITS'(1);
         end
      end else if (remain_ff != '0) begin
         word_in   = xs_step(word_ff);
         remain_in = remain_ff - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
      end else begin
         remain_ff <= remain_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign busy = (remain_ff != '0);
   assign word = word_ff;

endmodule

FILE: hdl/pixel_xor_chain_cipher.sv
`timescale 1ns / 1ps

// pixel xor chaining cipher: each 24-bit bgr pixel is xored with the low three
// bytes of an xorshift32 keystream word (shifts 13, 17, 5) and with a chaining
// value; pixel 0 of a frame chains with start_value, later pixels with the
// previous ciphertext pixel (the output when encrypting, the input when
// decrypting). at the first pixel of a frame the generator reloads key_seed and
// is stepped pixel_count times, one step per clock in a single shared step
// unit, while every later pixel takes one step. a pixel completes once its
// steps are done and the output register is free, so a result still waiting
// there holds off completion while the receiver stalls. one pixel is in flight
// at a time and req_tready is low while it is worked on. rsp_tlast marks the
// last pixel of a frame, after which the block rearms for the next frame.
// register writes never reset the frame position; program the registers while
// idle.
module pixel_xor_chain_cipher #(
   parameter int COUNT_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   // input pixel transaction
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // in_blue [7:0], in_green [15:8], in_red [23:16]
   // result pixel transaction
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // out_blue [7:0], out_green [15:8], out_red [23:16]
   output logic        rsp_tlast,   // frame_end
   // register port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [pxcc_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import pxcc_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   // configuration registers
   logic [WORD_BITS-1:0] key_seed_ff;
   logic [PIX_BITS-1:0]  start_value_ff;
   logic [PIX_BITS-1:0]  pixel_count_ff;
   logic                 decrypt_mode_ff;

   // sequencer and frame state
   state_type             state_ff;
   logic [COUNT_BITS-1:0] pixel_index_ff;
   logic [PIX_BITS-1:0]   chain_ff;
   logic [PIX_BITS-1:0]   pixel_ff;
   logic                  rsp_valid_ff;
   logic [PIX_BITS-1:0]   rsp_data_ff;
   logic                  rsp_last_ff;

   logic                  csr_write;
   csr_reg_type           csr_reg;
   logic                  req_accept;
   logic                  rsp_free;
   logic                  finish;
   logic [COUNT_BITS-1:0] count;
   logic                  frame_last;
   logic [PIX_BITS-1:0]   result_in;
   logic [PIX_BITS-1:0]   chain_in;
   ks_ctrl_type           ks_ctrl;
   logic                  ks_busy;
   logic [WORD_BITS-1:0]  ks_word;

   // register port, writes complete in the access phase
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_reg    = csr_reg_type'(csr_paddr[CSR_ADDR_BITS-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_seed_ff     <= WORD_BITS'(1);
         start_value_ff  <= '0;
         pixel_count_ff  <= PIX_BITS'(1);
         decrypt_mode_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_reg)
            REG_KEY_SEED:     key_seed_ff     <= csr_pwdata;
            REG_START_VALUE:  start_value_ff  <= csr_pwdata[PIX_BITS-1:0];
            REG_PIXEL_COUNT:  pixel_count_ff  <= csr_pwdata[PIX_BITS-1:0];
            REG_DECRYPT_MODE: decrypt_mode_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_reg)
         REG_KEY_SEED:     csr_prdata = key_seed_ff;
         REG_START_VALUE:  csr_prdata = 32'(start_value_ff);
         REG_PIXEL_COUNT:  csr_prdata = 32'(pixel_count_ff);
         REG_DECRYPT_MODE: csr_prdata = 32'(decrypt_mode_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // frame length seen modulo 2^COUNT_BITS
   assign count = COUNT_BITS'(pixel_count_ff);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid & req_tready;

   // first pixel of a frame reloads the seed and runs the skip,
   // later pixels advance the generator once
   assign ks_ctrl.start  = req_accept;
   assign ks_ctrl.reload = (pixel_index_ff == '0);

   pxcc_keystream #(
      .COUNT_BITS (COUNT_BITS)
   ) u_keystream (
      .clock (clock),
      .reset (reset),
      .ctrl  (ks_ctrl),
      .seed  (key_seed_ff),
      .steps (count),
      .busy  (ks_busy),
      .word  (ks_word)
   );

   // result register frees when empty or taken this cycle
   assign rsp_free = ~rsp_valid_ff | rsp_tready;
   assign finish   = (state_ff == ST_RUN) & ~ks_busy & rsp_free;

   assign result_in  = pixel_ff ^ ks_word[PIX_BITS-1:0] ^ chain_ff;
   assign chain_in   = decrypt_mode_ff ? pixel_ff : result_in;
   assign frame_last = ({1'b0, pixel_index_ff} + (COUNT_BITS+1)'(1)) >= {1'b0, count};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         pixel_index_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && !finish) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (finish) begin
                  state_ff       <= ST_IDLE;
                  rsp_valid_ff   <= 1'b1;
                  rsp_data_ff    <= result_in;
                  rsp_last_ff    <= frame_last;
                  pixel_index_ff <= frame_last ? '0 : pixel_index_ff + COUNT_BITS'(1);
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         pixel_ff <= req_tdata;
         if (pixel_index_ff == '0) begin
            chain_ff <= start_value_ff;
         end
      end
      if (finish) begin
         chain_ff <= chain_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: hdl/pxcc_checker.sv
`timescale 1ns / 1ps

`include "pixel_xor_chain_cipher_assert.svh"

module pxcc_port_props (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        csr_psel,
   input logic        csr_pready
);

   logic rsp_stall;
   logic req_take;

   assign rsp_stall = rsp_tvalid & ~rsp_tready;
   assign req_take  = req_tvalid & req_tready;

   // a stalled result holds its payload
   `PXCC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // one pixel in flight: busy right after a transaction is taken
   `PXCC_ASSERT_NEXT(a_busy_after_take, clock, reset, req_take, !req_tready)

   // a new result only comes out of a busy cycle
   `PXCC_ASSERT_NOW(a_rsp_from_work, clock, reset, $rose(rsp_tvalid), $past(!req_tready))

   // the register port never waits
   `PXCC_ASSERT_NOW(a_pready_high, clock, reset, csr_psel, csr_pready)

endmodule

bind pixel_xor_chain_cipher pxcc_port_props u_pxcc_port_props (.*);
